// ----- hw/rtl/cle_pkg.sv -----
// Shared constants, codes and types of the compacting list engine.
`default_nettype none

package cle_pkg;

    // List capacity and field widths
    localparam int DEPTH     = 64;
    localparam int OPCODE_W  = 3;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    // Internal widths derived from the capacity
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int SCAN_W = $clog2(DEPTH);

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_VALUE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_AT    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_GET          = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SET          = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } cle_state_t;

    // Command broadcast from the sequencer to every cell
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  key;
        logic [CNT_W-1:0]    count;
        logic                scan_clr;
        logic                wr_en;
        logic [CMP_W-1:0]    wr_pos;
        logic [VALUE_W-1:0]  wr_data;
        logic                shift_en;
    } cle_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cle_cell.sv -----
// One list cell: holds an entry and hands the match flag and read data up the chain.
`default_nettype none

module cle_cell import cle_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CMP_W-1:0]   pos,
    input  wire cle_cmd_t           cmd,
    input  wire logic [VALUE_W-1:0] up_entry,
    input  wire logic               flag_in,
    input  wire logic [VALUE_W-1:0] data_in,
    output logic      [VALUE_W-1:0] entry,
    output logic                    flag_out,
    output logic      [VALUE_W-1:0] data_out
);

    logic [VALUE_W-1:0] entry_reg;
    logic               flag_reg;
    logic               flag_next;
    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               hit;
    logic               at_or_after;

    // Decide whether this cell is the one the command points at
    always_comb
    begin
        hit = 1'b0;
        if (cmd.op == OP_REMOVE_VALUE)
        begin
            hit = (entry_reg == cmd.key) && (pos < CMP_W'(cmd.count));
        end
        else if ((cmd.op == OP_REMOVE_AT) || (cmd.op == OP_GET))
        begin
            hit = (pos == CMP_W'(cmd.idx));
        end
        at_or_after = flag_in | hit;
    end

    // Pass the flag and the selected data to the next cell
    always_comb
    begin
        flag_next = cmd.scan_clr ? 1'b0 : at_or_after;
        data_next = hit ? entry_reg : data_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    // Write, or close the gap by taking the entry of the cell above
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (cmd.wr_en && (pos == cmd.wr_pos))
        begin
            entry_reg <= cmd.wr_data;
        end
        else if (cmd.shift_en && at_or_after)
        begin
            entry_reg <= up_entry;
        end
    end

    assign entry    = entry_reg;
    assign flag_out = flag_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cle_ctrl.sv -----
// Sequencer: decodes each item, runs the chain scan and holds the result register.
`default_nettype none

module cle_ctrl import cle_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [OPCODE_W-1:0]        opcode,
    input  wire logic [INDEX_W-1:0]         index,
    input  wire logic signed [VALUE_W-1:0]  value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [VALUE_W-1:0]       read_data,
    output logic      [STATUS_W-1:0]        status,
    output logic      [COUNT_W-1:0]         count,
    output cle_cmd_t                        cmd,
    input  wire logic                       flag_top,
    input  wire logic [VALUE_W-1:0]         data_top
);

    cle_state_t          state_reg;
    cle_state_t          state_next;
    logic [SCAN_W-1:0]   cnt_reg;
    logic [SCAN_W-1:0]   cnt_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [VALUE_W-1:0]  key_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  out_data_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic                out_free;
    logic                in_fire;
    logic                in_range;
    logic                is_full;
    logic                scan_start;
    logic                load;
    logic [VALUE_W-1:0]  res_data;
    logic [STATUS_W-1:0] res_status;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign in_fire  = in_valid && !in_stall;
    assign in_range = CMP_W'(index) < CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // Next state and scan counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (scan_start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + SCAN_W'(1);
                if (cnt_reg == SCAN_W'(DEPTH - 1))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the cells and the result of each item
    always_comb
    begin
        cmd.op       = op_reg;
        cmd.idx      = idx_reg;
        cmd.key      = key_reg;
        cmd.count    = count_reg;
        cmd.scan_clr = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.wr_pos   = '0;
        cmd.wr_data  = $unsigned(value);
        cmd.shift_en = 1'b0;
        scan_start   = 1'b0;
        load         = 1'b0;
        res_data     = '0;
        res_status   = ST_OK;
        count_next   = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.scan_clr = 1'b1;
                    unique case (opcode)
                        OP_APPEND:
                        begin
                            load = 1'b1;
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_pos = CMP_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_SET:
                        begin
                            load = 1'b1;
                            if (in_range)
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_pos = CMP_W'(index);
                            end
                            else
                            begin
                                res_status = ST_RANGE;
                            end
                        end
                        OP_REMOVE_VALUE:
                        begin
                            scan_start = 1'b1;
                        end
                        OP_REMOVE_AT, OP_GET:
                        begin
                            if (in_range)
                            begin
                                scan_start = 1'b1;
                            end
                            else
                            begin
                                load       = 1'b1;
                                res_status = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // flags ripple through the chain
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    unique case (op_reg)
                        OP_REMOVE_VALUE:
                        begin
                            if (flag_top)
                            begin
                                cmd.shift_en = 1'b1;
                                count_next   = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_status = ST_NOT_FOUND;
                            end
                        end
                        OP_REMOVE_AT:
                        begin
                            cmd.shift_en = 1'b1;
                            count_next   = count_reg - CNT_W'(1);
                        end
                        OP_GET:
                        begin
                            res_data = data_top;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the item fields and the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= opcode;
            idx_reg <= index;
            key_reg <= $unsigned(value);
        end
        if (load)
        begin
            out_data_reg   <= res_data;
            out_status_reg <= res_status;
            out_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = $signed(out_data_reg);
    assign status    = out_status_reg;
    assign count     = out_count_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/compacting_list_engine_core.sv -----
// Top level of the compacting list engine: sequencer and a chain of list cells.
//
//  channel | direction | handshake             | fields
//  --------+-----------+-----------------------+--------------------------
//  in      | to core   | in_valid / in_stall   | opcode, index, value
//  out     | from core | out_valid / out_stall | read_data, status, count
//
// Append, set, unused codes and out-of-range requests are answered from the idle state.
// Remove-value, and remove-at or get within range, run a scan state and then a
// commit state: the match flag moves up the cell chain one cell a cycle.
// Reset clears the entry count; entries hold no reset value and need no pass.
// One output register holds a result; the input stalls while a scan or its commit
// runs, or while a finished result waits stalled at the output.
`default_nettype none

module compacting_list_engine_core import cle_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [OPCODE_W-1:0]        opcode,
    input  wire logic [INDEX_W-1:0]         index,
    input  wire logic signed [VALUE_W-1:0]  value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [VALUE_W-1:0]       read_data,
    output logic      [STATUS_W-1:0]        status,
    output logic      [COUNT_W-1:0]         count
);

    cle_cmd_t           cmd;
    logic               flag_w  [DEPTH+1];
    logic [VALUE_W-1:0] data_w  [DEPTH+1];
    logic [VALUE_W-1:0] entry_w [DEPTH];

    assign flag_w[0] = 1'b0;
    assign data_w[0] = '0;

    cle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data),
        .status    (status),
        .count     (count),
        .cmd       (cmd),
        .flag_top  (flag_w[DEPTH]),
        .data_top  (data_w[DEPTH])
    );

    // Build the chain; the top cell takes its own entry on a shift
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [VALUE_W-1:0] up_entry;

        if (k < DEPTH - 1)
        begin : g_mid
            assign up_entry = entry_w[k+1];
        end
        else
        begin : g_top
            assign up_entry = entry_w[k];
        end

        cle_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .pos      (CMP_W'(k)),
            .cmd      (cmd),
            .up_entry (up_entry),
            .flag_in  (flag_w[k]),
            .data_in  (data_w[k]),
            .entry    (entry_w[k]),
            .flag_out (flag_w[k+1]),
            .data_out (data_w[k+1])
        );
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cle_checker.sv -----
// Port-level checks of the compacting list engine, bound to the top level.
`default_nettype none

module cle_checker import cle_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic signed [VALUE_W-1:0]  read_data,
    input wire logic [STATUS_W-1:0]        status,
    input wire logic [COUNT_W-1:0]         count
);

    // A full report comes only with the list at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (count == COUNT_W'(DEPTH)))
        else $error("full status with count below capacity");

    // Read data is non-zero only on a successful operation
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (read_data != 0)) |-> (status == ST_OK))
        else $error("read data returned with an error status");

    // A stalled result blocks new items
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("item accepted while result register is held");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(read_data) && $stable(status) && $stable(count)))
        else $error("stalled result changed");

endmodule

bind compacting_list_engine_core cle_checker u_cle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .status    (status),
    .count     (count)
);

`default_nettype wire
